@@ rtl/ctem_pkg.sv @@
// Shared widths, constants and controller/datapath interface types for the cycle-time monitor.
`default_nettype none

package ctem_pkg;

  localparam int FX_W        = 50;                  // ns value, 8 fraction bits
  localparam int FRAC_W      = 8;
  localparam int NS_W        = 32;
  localparam int DIFF_W      = 32;
  localparam int TICK_W      = 64;
  localparam int TPU_W       = 16;
  localparam int WCNT_W      = 7;
  localparam int SCALE_W     = 18;
  localparam int DIV_W       = 54;                  // holds 9*avg + sample
  localparam int DIV_BITS    = 2;                   // quotient bits per cycle
  localparam int DIV_CYCLES  = DIV_W / DIV_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES + 1);

  localparam logic [TPU_W-1:0]   TPU_RESET = 16'd1000;
  localparam logic [SCALE_W-1:0] NS_SCALE  = 18'd256000;  // 1000 ns/us, 8 fraction bits
  localparam logic [TPU_W-1:0]   EWMA_DIV  = 16'd10;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic load_in;      // capture the accepted item
    logic start;        // clear / skip / launch scaling divide
    logic div_step;     // advance the shared divider
    logic take_sample;  // commit scaled sample, launch average divide after warm-up
    logic take_avg;     // commit new average, track max/min
    logic load_out;     // copy statistics into the output register
  } ctem_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_step;
    logic div_done;
    logic warm;         // next sample is still a warm-up sample
  } ctem_sts_t;

endpackage

`default_nettype wire

@@ rtl/cycle_time_ewma_monitor.sv @@
// Top level of the cycle-time EWMA monitor: controller plus datapath.
//
//  channel  direction  handshake           payload
//  -------  ---------  ------------------  -------------------------------------------
//  in       to block   in_valid/in_stall   op, begin_ticks, end_ticks, step_mode
//  out      from block out_valid/out_stall sample_ns, average_ns, maximum_ns,
//                                          minimum_ns, warming, updated
//  cfg      to block   cfg_we              cfg_data (ticks_per_usec)
//
// One item at a time. A normal sample makes two passes through the shared 2-bit-per-cycle
// divider, one for the tick-to-ns scaling and one for the divide by ten of the moving
// average. A warm-up sample skips the second pass; clear and step-mode items skip both.
// The next item is taken in the cycle after the hand-off at the earliest. rst is synchronous:
// ticks_per_usec returns to 1000 and all statistics clear to zero. A stalled result sits
// in the output register while the next item is worked on; that item waits at its hand-off.
`default_nettype none

module cycle_time_ewma_monitor import ctem_pkg::*; #(
  parameter int WARMUP = 100
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              cfg_we,
  input  wire logic [TPU_W-1:0]  cfg_data,
  // input items
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              op,
  input  wire logic [TICK_W-1:0] begin_ticks,
  input  wire logic [TICK_W-1:0] end_ticks,
  input  wire logic              step_mode,
  // result items
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [NS_W-1:0]        sample_ns,
  output logic [NS_W-1:0]        average_ns,
  output logic [NS_W-1:0]        maximum_ns,
  output logic [NS_W-1:0]        minimum_ns,
  output logic                   warming,
  output logic                   updated
);

  ctem_cmd_t cmd;
  ctem_sts_t sts;

  // sequencing: accept, scale, divide, update, hand off
  ctem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // statistics state, divider and output register
  ctem_dp #(
    .WARMUP (WARMUP)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .op          (op),
    .begin_ticks (begin_ticks),
    .end_ticks   (end_ticks),
    .step_mode   (step_mode),
    .cmd         (cmd),
    .sts         (sts),
    .sample_ns   (sample_ns),
    .average_ns  (average_ns),
    .maximum_ns  (maximum_ns),
    .minimum_ns  (minimum_ns),
    .warming     (warming),
    .updated     (updated)
  );

endmodule

`default_nettype wire

@@ rtl/ctem_ctrl.sv @@
// Sequencing state machine for the cycle-time monitor.
`default_nettype none

module ctem_ctrl import ctem_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire ctem_sts_t sts,
  output ctem_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_SAMP = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_AVG  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.start  = 1'b1;
        state_next = (sts.is_clear || sts.is_step) ? S_OUT : S_DIV1;
      end
      S_DIV1: begin
        if (sts.div_done) begin
          state_next = S_SAMP;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_SAMP: begin
        cmd.take_sample = 1'b1;
        state_next      = sts.warm ? S_OUT : S_DIV2;
      end
      S_DIV2: begin
        if (sts.div_done) begin
          state_next = S_AVG;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_AVG: begin
        cmd.take_avg = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ctem_dp.sv @@
// Datapath: scaling multiply, shared radix-4 divider, EWMA and max/min statistics.
`default_nettype none

module ctem_dp import ctem_pkg::*; #(
  parameter int WARMUP = 100
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [TPU_W-1:0]  cfg_data,
  input  wire logic              op,
  input  wire logic [TICK_W-1:0] begin_ticks,
  input  wire logic [TICK_W-1:0] end_ticks,
  input  wire logic              step_mode,
  input  wire ctem_cmd_t         cmd,
  output ctem_sts_t              sts,
  output logic [NS_W-1:0]        sample_ns,
  output logic [NS_W-1:0]        average_ns,
  output logic [NS_W-1:0]        maximum_ns,
  output logic [NS_W-1:0]        minimum_ns,
  output logic                   warming,
  output logic                   updated
);

  function automatic logic [NS_W-1:0] to_ns(input logic [FX_W-1:0] fx);
    logic [NS_W-1:0] r;
    if (fx[FX_W-1:FRAC_W+NS_W] != '0) begin
      r = '1;
    end else begin
      r = fx[FRAC_W+NS_W-1:FRAC_W];
    end
    return r;
  endfunction

  logic [TPU_W-1:0]     ticks_per_usec;
  logic [WCNT_W-1:0]    warmup_count;
  logic [FX_W-1:0]      average_fx;
  logic [FX_W-1:0]      maximum_fx;
  logic [FX_W-1:0]      minimum_fx;
  logic [FX_W-1:0]      last_sample_fx;
  logic                 op_q;
  logic                 step_q;
  logic [DIFF_W-1:0]    diff;
  logic                 upd;

  // divider: dividend bits shift out the top while quotient bits shift in below
  logic [DIV_W-1:0]     quo;
  logic [TPU_W-1:0]     rem;
  logic [TPU_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DIV_W-1:0]     quo_next;
  logic [TPU_W-1:0]     rem_next;

  logic                 warm;
  logic [FX_W-1:0]      q_fx;
  logic [DIV_W-1:0]     ewma_sum;
  logic [FX_W-1:0]      product;

  assign warm     = (warmup_count < WCNT_W'(WARMUP));
  assign q_fx     = quo[FX_W-1:0];
  assign ewma_sum = DIV_W'({average_fx, 3'b000}) + DIV_W'(average_fx) + DIV_W'(q_fx);
  assign product  = FX_W'(diff) * FX_W'(NS_SCALE);

  assign sts.is_clear = (op_q == OP_CLEAR);
  assign sts.is_step  = step_q;
  assign sts.div_done = (div_cnt == '0);
  assign sts.warm     = warm;

  always_comb begin
    logic [TPU_W:0]   t;
    logic [DIV_W-1:0] sh;
    logic [TPU_W-1:0] r;
    sh = quo;
    r  = rem;
    for (int i = 0; i < DIV_BITS; i++) begin
      t  = {r, sh[DIV_W-1]};
      sh = {sh[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t     = t - {1'b0, dvs};
        sh[0] = 1'b1;
      end
      r = t[TPU_W-1:0];
    end
    quo_next = sh;
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_usec <= TPU_RESET;
      warmup_count   <= '0;
      average_fx     <= '0;
      maximum_fx     <= '0;
      minimum_fx     <= '0;
      last_sample_fx <= '0;
      div_cnt        <= '0;
    end else begin
      if (cfg_we) begin
        ticks_per_usec <= cfg_data;
      end
      if (cmd.start) begin
        if (op_q == OP_CLEAR) begin
          warmup_count   <= '0;
          average_fx     <= '0;
          maximum_fx     <= '0;
          minimum_fx     <= '0;
          last_sample_fx <= '0;
        end else if (!step_q) begin
          div_cnt <= DIV_CNT_W'(DIV_CYCLES);
        end
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt - 1'b1;
      end
      if (cmd.take_sample) begin
        last_sample_fx <= q_fx;
        if (warm) begin
          warmup_count <= warmup_count + 1'b1;
          average_fx   <= q_fx;
          maximum_fx   <= q_fx;
          minimum_fx   <= q_fx;
        end else begin
          div_cnt <= DIV_CNT_W'(DIV_CYCLES);
        end
      end
      if (cmd.take_avg) begin
        average_fx <= q_fx;
        if (q_fx > maximum_fx) begin
          maximum_fx <= q_fx;
        end
        if (q_fx < minimum_fx) begin
          minimum_fx <= q_fx;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q   <= op;
      step_q <= step_mode;
      diff   <= end_ticks[DIFF_W-1:0] - begin_ticks[DIFF_W-1:0];
    end
    if (cmd.start) begin
      upd <= (op_q == OP_CLEAR) || !step_q;
      quo <= DIV_W'(product);
      rem <= '0;
      dvs <= (ticks_per_usec == '0) ? TPU_W'(1) : ticks_per_usec;
    end
    if (cmd.div_step) begin
      quo <= quo_next;
      rem <= rem_next;
    end
    if (cmd.take_sample) begin
      quo <= ewma_sum;
      rem <= '0;
      dvs <= EWMA_DIV;
    end
    if (cmd.load_out) begin
      sample_ns  <= to_ns(last_sample_fx);
      average_ns <= to_ns(average_fx);
      maximum_ns <= to_ns(maximum_fx);
      minimum_ns <= to_ns(minimum_fx);
      warming    <= warm;
      updated    <= upd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ctem_checker.sv @@
// Port-level assertions for the cycle-time monitor, bound to the top level.
`default_nettype none

module ctem_props import ctem_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [NS_W-1:0]   average_ns,
  input wire logic [NS_W-1:0]   maximum_ns,
  input wire logic [NS_W-1:0]   minimum_ns,
  input wire logic              updated
);

  // a held result stays valid and keeps its average and updated flag
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(average_ns) && $stable(updated))
    else $error("stalled result changed");

  // the average of a valid result lies between the tracked minimum and maximum
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (minimum_ns <= average_ns) && (average_ns <= maximum_ns))
    else $error("min/avg/max out of order");

  // one item in flight: an accepted item makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after accept");

  // a result only appears at the end of an item's work
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without item in progress");

endmodule

bind cycle_time_ewma_monitor ctem_props u_ctem_props (.*);

`default_nettype wire
